// File: rtl/core/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

   localparam int MODE_W     = 2;
   localparam int IDX_W      = 4;
   localparam int TICK_W     = 32;
   localparam int CNT_W      = 5;
   localparam int MAX_SCAN   = 16;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_WORD_LSB = 2;
   localparam logic CSR_TIU_WORD = 1'b0;

   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ARM    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DISARM = 2'd2;

   typedef struct packed {
      logic start_scan;
      logic cmd_wr;
      logic scan_en;
      logic flush_en;
   } ptb_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic flush_done;
   } ptb_sts_type;

endpackage

// File: rtl/core/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer that accepts commands and walks the datapath through a tick.
// ----------------------------------------------------------------------------
module ptb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic [ptb_pkg::MODE_W-1:0] req_mode,
   output logic                     req_tready,
   output ptb_pkg::ptb_cmd_type     cmd,
   input  ptb_pkg::ptb_sts_type     sts
);
   import ptb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.start_scan = accept && (req_mode == MODE_TICK);
      cmd.cmd_wr     = accept && (req_mode != MODE_TICK);
      cmd.scan_en    = (state_ff == ST_SCAN);
      cmd.flush_en   = (state_ff == ST_FLUSH);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (sts.flush_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/ptb_dpath.sv
// ----------------------------------------------------------------------------
// ptb_dpath
// Timer memories, scan pipeline, pending expiry and result register.
// ----------------------------------------------------------------------------
module ptb_dpath #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ptb_pkg::ptb_cmd_type        cmd,
   output ptb_pkg::ptb_sts_type        sts,
   input  logic [ptb_pkg::CNT_W-1:0]   timers_in_use,
   input  logic [ptb_pkg::MODE_W-1:0]  mode,
   input  logic [ptb_pkg::IDX_W-1:0]   timer_index,
   input  logic [ptb_pkg::TICK_W-1:0]  timeout_ticks,
   input  logic [ptb_pkg::TICK_W-1:0]  reload_ticks,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [ptb_pkg::IDX_W-1:0]   rsp_index,
   output logic                        rsp_last
);
   import ptb_pkg::*;

   localparam int AW       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int SCAN_LIM = (NUM_TIMERS < MAX_SCAN) ? NUM_TIMERS : MAX_SCAN;

   logic [TICK_W-1:0] rem_mem_ff [NUM_TIMERS];
   logic [TICK_W-1:0] rel_mem_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] rem_vld_ff;
   logic [NUM_TIMERS-1:0] rel_vld_ff;

   logic [TICK_W-1:0] rd_rem_ff;
   logic [TICK_W-1:0] rd_rel_ff;
   logic              rd_remv_ff;
   logic              rd_relv_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             b_vld_ff, b_vld_in;
   logic [IDX_W-1:0] b_idx_ff, b_idx_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             out_vld_ff, out_vld_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic             out_last_ff, out_last_in;

   logic [CNT_W-1:0]  n_active;
   logic [TICK_W-1:0] b_rem;
   logic [TICK_W-1:0] b_rel;
   logic              b_live;
   logic              b_exp;
   logic              out_free;
   logic              stall;
   logic              adv;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              idx_ok;
   logic              rem_wr;
   logic              rel_wr;
   logic [AW-1:0]     wr_addr;
   logic [TICK_W-1:0] rem_wdata;

   assign n_active = (timers_in_use > CNT_W'(SCAN_LIM)) ? CNT_W'(SCAN_LIM) : timers_in_use;

   assign b_rem    = rd_remv_ff ? rd_rem_ff : '0;
   assign b_rel    = rd_relv_ff ? rd_rel_ff : '0;
   assign b_live   = b_vld_ff && (b_rem != '0);
   assign b_exp    = b_vld_ff && (b_rem == TICK_W'(1));
   assign out_free = !out_vld_ff || rsp_ready;
   assign stall    = b_exp && pend_vld_ff && !out_free;
   assign adv      = cmd.scan_en && !stall;
   assign rd_en    = adv && (cnt_ff < n_active);
   assign rd_addr  = AW'(cnt_ff);

   assign idx_ok = ({1'b0, timer_index} < n_active);

   always_comb begin
      rem_wr    = 1'b0;
      rel_wr    = 1'b0;
      wr_addr   = AW'(b_idx_ff);
      rem_wdata = b_exp ? b_rel : (b_rem - TICK_W'(1));
      if (cmd.cmd_wr && idx_ok && (mode == MODE_ARM)) begin
         rem_wr    = 1'b1;
         rel_wr    = 1'b1;
         wr_addr   = AW'(timer_index);
         rem_wdata = timeout_ticks;
      end else if (cmd.cmd_wr && idx_ok && (mode == MODE_DISARM)) begin
         rem_wr    = 1'b1;
         wr_addr   = AW'(timer_index);
         rem_wdata = '0;
      end else if (adv && b_live) begin
         rem_wr = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rem_wr) begin
         rem_mem_ff[wr_addr] <= rem_wdata;
      end
      if (rel_wr) begin
         rel_mem_ff[wr_addr] <= reload_ticks;
      end
      if (rd_en) begin
         rd_rem_ff  <= rem_mem_ff[rd_addr];
         rd_rel_ff  <= rel_mem_ff[rd_addr];
         rd_remv_ff <= rem_vld_ff[rd_addr];
         rd_relv_ff <= rel_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_vld_ff <= '0;
         rel_vld_ff <= '0;
      end else begin
         if (rem_wr) begin
            rem_vld_ff[wr_addr] <= 1'b1;
         end
         if (rel_wr) begin
            rel_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_comb begin
      cnt_in      = cnt_ff;
      b_vld_in    = b_vld_ff;
      b_idx_in    = b_idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;
      out_idx_in  = out_idx_ff;
      out_last_in = out_last_ff;

      if (cmd.start_scan) begin
         cnt_in   = '0;
         b_vld_in = 1'b0;
      end else if (adv) begin
         b_vld_in = rd_en;
         if (rd_en) begin
            cnt_in   = cnt_ff + CNT_W'(1);
            b_idx_in = cnt_ff[IDX_W-1:0];
         end
         if (b_exp) begin
            pend_vld_in = 1'b1;
            pend_idx_in = b_idx_ff;
            if (pend_vld_ff) begin
               out_vld_in  = 1'b1;
               out_idx_in  = pend_idx_ff;
               out_last_in = 1'b0;
            end
         end
      end

      if (cmd.flush_en && pend_vld_ff && out_free) begin
         pend_vld_in = 1'b0;
         out_vld_in  = 1'b1;
         out_idx_in  = pend_idx_ff;
         out_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         b_vld_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         b_vld_ff    <= b_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      b_idx_ff    <= b_idx_in;
      pend_idx_ff <= pend_idx_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      sts.scan_done  = (cnt_ff == n_active) && !b_vld_ff;
      sts.flush_done = !pend_vld_ff || out_free;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_index = out_idx_ff;
   assign rsp_last  = out_last_ff;

endmodule

// File: rtl/core/periodic_timer_bank_core.sv
// Arm, disarm and unused commands complete when accepted; a tick scans the n timers in use
// and then flushes the pending expiry, and result stalls can hold it longer.
// One arm or disarm command per cycle while idle; no command is taken until a tick ends.
// A full result register stalls the scan once a second expiry waits behind it.
// Reset is synchronous and clears all timers, the register and the result channel.
// ----------------------------------------------------------------------------
// periodic_timer_bank_core
// Bank of countdown timers with arm, disarm and tick commands.
// ----------------------------------------------------------------------------
module periodic_timer_bank_core #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // timer_index[3:0], timeout_ticks[35:4], reload_ticks[67:36], zero pad.
   input  logic [ptb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[1:0].
   input  logic [ptb_pkg::MODE_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // expired_index[3:0], zero pad.
   output logic [ptb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import ptb_pkg::*;

   ptb_cmd_type      cmd;
   ptb_sts_type      sts;
   logic [CNT_W-1:0] tiu_ff, tiu_in;
   logic             csr_hit;
   logic [IDX_W-1:0] rsp_index;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_WORD_LSB] == CSR_TIU_WORD);

   always_comb begin
      tiu_in = tiu_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         tiu_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tiu_ff <= '0;
      end else begin
         tiu_ff <= tiu_in;
      end
   end

   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-CNT_W){1'b0}}, tiu_ff} : '0;

   ptb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   ptb_dpath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .timers_in_use (tiu_ff),
      .mode          (req_tuser),
      .timer_index   (req_tdata[IDX_W-1:0]),
      .timeout_ticks (req_tdata[IDX_W +: TICK_W]),
      .reload_ticks  (req_tdata[IDX_W+TICK_W +: TICK_W]),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_index     (rsp_index),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W-IDX_W){1'b0}}, rsp_index};

endmodule

// File: rtl/core/ptb_checker.sv
// ----------------------------------------------------------------------------
// ptb_checker
// Port-level checks for the periodic timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module ptb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ptb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           csr_pready
);
   import ptb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Result transaction changed while stalled.");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:IDX_W] == '0))
      else $error("Result padding bits are not zero.");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("Command accepted while a tick still has expiries to report.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("Register port not ready.");

endmodule

bind periodic_timer_bank_core ptb_checker u_ptb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
